// ----- sv/jd2d_pkg.sv -----
// ----------------------------------------------------------------------------
// jd2d_pkg
// Types and constants shared by the day number to date pipeline.
// ----------------------------------------------------------------------------
package jd2d_pkg;

    // first gregorian day, 15 october 1582
    localparam logic [31:0] GREG_START   = 32'd2299161;

    // 400-year cycle
    localparam logic [17:0] CYC400_DAYS  = 18'd146097;
    localparam logic [34:0] CYC400_OFS   = 35'd274277;
    localparam logic [17:0] CYC400_RECIP = 18'((64'd1 << 35) / 64'd146097);
    localparam logic [32:0] GREG_BIAS    = 33'd38;
    localparam logic [32:0] DAY_OFS      = 33'd1401;

    // 4-year cycle
    localparam logic [10:0] CYC4_DAYS    = 11'd1461;
    localparam logic [24:0] CYC4_RECIP   = 25'((64'd1 << 35) / 64'd1461);

    // month split
    localparam logic [7:0]  MON5_DAYS    = 8'd153;
    localparam logic [9:0]  MON5_RECIP   = 10'd857;
    localparam logic [7:0]  DIV5_RECIP   = 8'd205;
    localparam logic [3:0]  MONTHS       = 4'd12;

    // year numbering
    localparam logic [24:0] YEAR_BIAS    = 25'd4716;
    localparam logic [24:0] BC_BIAS      = 25'd4717;

    // stage 4 to stage 5
    typedef struct packed {
        logic        valid;
        logic [34:0] e;
    } jd2d_e_t;

    // stage 7 to stage 8
    typedef struct packed {
        logic        valid;
        logic [10:0] h;
        logic [24:0] q4;
    } jd2d_h_t;

    // result transaction
    typedef struct packed {
        logic        valid;
        logic [4:0]  day_of_month;
        logic [3:0]  month;
        logic [23:0] year;
        logic        before_christ;
    } jd2d_res_t;

endpackage

// ----- sv/jd2d_greg.sv -----
// ----------------------------------------------------------------------------
// jd2d_greg
// Stages 1 to 4: 400-year cycle count and gregorian century correction.
// ----------------------------------------------------------------------------
module jd2d_greg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [31:0]        day_number,
    output jd2d_pkg::jd2d_e_t  out
);
    import jd2d_pkg::*;

    // stage 1
    logic        v1_reg;
    logic [31:0] j1_reg;
    logic        greg1_reg;
    logic [34:0] t1_reg;
    logic [34:0] t1_next;

    // stage 2
    logic        v2_reg;
    logic [31:0] j2_reg;
    logic        greg2_reg;
    logic [34:0] t2_reg;
    logic [17:0] qe2_reg;
    logic [36:0] prod2;
    logic [17:0] qe2_next;

    // stage 3
    logic        v3_reg;
    logic [31:0] j3_reg;
    logic        greg3_reg;
    logic [17:0] qe3_reg;
    logic [18:0] r3_reg;
    logic [35:0] prod3;
    logic [18:0] r3_next;

    // stage 4
    logic        v4_reg;
    logic [34:0] e4_reg;
    logic [17:0] q4;
    logic [19:0] q4x3;
    logic [32:0] adj4;
    logic [32:0] f4;
    logic [34:0] e4_next;

    assign t1_next  = {1'b0, day_number, 2'b00} + CYC400_OFS;

    assign prod2    = 37'(t1_reg[34:16]) * 37'(CYC400_RECIP);
    assign qe2_next = prod2[36:19];

    assign prod3    = 36'(qe2_reg) * 36'(CYC400_DAYS);
    assign r3_next  = 19'(t2_reg - prod3[34:0]);

    always_comb
    begin
        priority if (r3_reg >= 19'({CYC400_DAYS, 1'b0}))
        begin
            q4 = qe3_reg + 18'd2;
        end
        else if (r3_reg >= 19'(CYC400_DAYS))
        begin
            q4 = qe3_reg + 18'd1;
        end
        else
        begin
            q4 = qe3_reg;
        end
        q4x3    = 20'(q4) + {1'b0, q4, 1'b0};
        adj4    = greg3_reg ? (33'(q4x3[19:2]) - GREG_BIAS) : '0;
        f4      = 33'(j3_reg) + DAY_OFS + adj4;
        e4_next = {f4, 2'b11};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        j1_reg    <= day_number;
        greg1_reg <= (day_number >= GREG_START);
        t1_reg    <= t1_next;
        j2_reg    <= j1_reg;
        greg2_reg <= greg1_reg;
        t2_reg    <= t1_reg;
        qe2_reg   <= qe2_next;
        j3_reg    <= j2_reg;
        greg3_reg <= greg2_reg;
        qe3_reg   <= qe2_reg;
        r3_reg    <= r3_next;
        e4_reg    <= e4_next;
    end

    assign out.valid = v4_reg;
    assign out.e     = e4_reg;

endmodule

// ----- sv/jd2d_cycle.sv -----
// ----------------------------------------------------------------------------
// jd2d_cycle
// Stages 5 to 7: 4-year cycle split into year count and day of year.
// ----------------------------------------------------------------------------
module jd2d_cycle (
    input  logic               clk,
    input  logic               rst_n,
    input  jd2d_pkg::jd2d_e_t  in,
    output jd2d_pkg::jd2d_h_t  out
);
    import jd2d_pkg::*;

    // stage 5
    logic        v5_reg;
    logic [34:0] e5_reg;
    logic [24:0] qe5_reg;
    logic [51:0] prod5;

    // stage 6
    logic        v6_reg;
    logic [24:0] qe6_reg;
    logic [12:0] r6_reg;
    logic [35:0] prod6;
    logic [12:0] r6_next;

    // stage 7
    logic        v7_reg;
    logic [10:0] h7_reg;
    logic [24:0] q7_reg;
    logic [24:0] q7_next;
    logic [12:0] rc7;
    logic [8:0]  g7;
    logic [10:0] h7_next;

    assign prod5   = 52'(in.e[34:8]) * 52'(CYC4_RECIP);
    assign prod6   = 36'(qe5_reg) * 36'(CYC4_DAYS);
    assign r6_next = 13'(e5_reg - prod6[34:0]);

    always_comb
    begin
        priority if (r6_reg >= 13'({CYC4_DAYS, 1'b0}))
        begin
            q7_next = qe6_reg + 25'd2;
            rc7     = r6_reg - 13'({CYC4_DAYS, 1'b0});
        end
        else if (r6_reg >= 13'(CYC4_DAYS))
        begin
            q7_next = qe6_reg + 25'd1;
            rc7     = r6_reg - 13'(CYC4_DAYS);
        end
        else
        begin
            q7_next = qe6_reg;
            rc7     = r6_reg;
        end
        g7      = rc7[10:2];
        h7_next = 11'({g7, 2'b00}) + 11'(g7) + 11'd2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            v5_reg <= in.valid;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        e5_reg  <= in.e;
        qe5_reg <= prod5[51:27];
        qe6_reg <= qe5_reg;
        r6_reg  <= r6_next;
        h7_reg  <= h7_next;
        q7_reg  <= q7_next;
    end

    assign out.valid = v7_reg;
    assign out.h     = h7_reg;
    assign out.q4    = q7_reg;

endmodule

// ----- sv/jd2d_month.sv -----
// ----------------------------------------------------------------------------
// jd2d_month
// Stages 8 to 11: month and day of month, then year numbering and era.
// ----------------------------------------------------------------------------
module jd2d_month (
    input  logic                 clk,
    input  logic                 rst_n,
    input  jd2d_pkg::jd2d_h_t    in,
    output jd2d_pkg::jd2d_res_t  out
);
    import jd2d_pkg::*;

    // stage 8
    logic        v8_reg;
    logic [10:0] h8_reg;
    logic [24:0] q8_reg;
    logic [3:0]  mq8_reg;
    logic [20:0] prod8;

    // stage 9
    logic        v9_reg;
    logic [7:0]  x9_reg;
    logic [3:0]  m9_reg;
    logic [24:0] q9_reg;
    logic [11:0] prod9;
    logic [7:0]  x9_next;
    logic [3:0]  mo9;
    logic [3:0]  m9_next;

    // stage 10
    logic        v10_reg;
    logic [4:0]  d10_reg;
    logic [3:0]  m10_reg;
    logic [24:0] yp10_reg;
    logic [15:0] prod10;
    logic [4:0]  d10_next;
    logic [24:0] yp10_next;

    // stage 11
    logic        v11_reg;
    logic [4:0]  d11_reg;
    logic [3:0]  m11_reg;
    logic [23:0] y11_reg;
    logic        bc11_reg;
    logic [23:0] y11_next;
    logic        bc11_next;

    assign prod8   = 21'(in.h) * 21'(MON5_RECIP);

    assign prod9   = 12'(mq8_reg) * 12'(MON5_DAYS);
    assign x9_next = 8'(12'(h8_reg) - prod9);
    assign mo9     = mq8_reg + 4'd2;
    assign m9_next = ((mo9 >= MONTHS) ? (mo9 - MONTHS) : mo9) + 4'd1;

    // jan and feb belong to the following year
    assign prod10    = 16'(x9_reg) * 16'(DIV5_RECIP);
    assign d10_next  = 5'(prod10[15:10]) + 5'd1;
    assign yp10_next = q9_reg + ((m9_reg <= 4'd2) ? 25'd1 : 25'd0);

    always_comb
    begin
        if (yp10_reg > YEAR_BIAS)
        begin
            y11_next  = 24'(yp10_reg - YEAR_BIAS);
            bc11_next = 1'b0;
        end
        else
        begin
            y11_next  = 24'(BC_BIAS - yp10_reg);
            bc11_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
            v11_reg <= 1'b0;
        end
        else
        begin
            v8_reg  <= in.valid;
            v9_reg  <= v8_reg;
            v10_reg <= v9_reg;
            v11_reg <= v10_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        h8_reg   <= in.h;
        q8_reg   <= in.q4;
        mq8_reg  <= prod8[20:17];
        x9_reg   <= x9_next;
        m9_reg   <= m9_next;
        q9_reg   <= q8_reg;
        d10_reg  <= d10_next;
        m10_reg  <= m9_reg;
        yp10_reg <= yp10_next;
        d11_reg  <= d10_reg;
        m11_reg  <= m10_reg;
        y11_reg  <= y11_next;
        bc11_reg <= bc11_next;
    end

    assign out.valid         = v11_reg;
    assign out.day_of_month  = d11_reg;
    assign out.month         = m11_reg;
    assign out.year          = y11_reg;
    assign out.before_christ = bc11_reg;

endmodule

// ----- sv/julian_day_to_date.sv -----
// ----------------------------------------------------------------------------
// julian_day_to_date
// Converts a julian day number into day, month, year and era flag.
// Throughput: one transaction per cycle; busy is always low.
// Latency is set by the 11 register stages, each with at most one multiply.
// Reset clears only the stage valid bits; no transaction is in flight after it.
// ----------------------------------------------------------------------------
module julian_day_to_date (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] day_number,
    output logic        done,
    output logic [4:0]  day_of_month,
    output logic [3:0]  month,
    output logic [23:0] year,
    output logic        before_christ
);
    import jd2d_pkg::*;

    jd2d_e_t   e_stage;
    jd2d_h_t   h_stage;
    jd2d_res_t res;
    logic      accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    jd2d_greg u_greg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .day_number (day_number),
        .out        (e_stage)
    );

    jd2d_cycle u_cycle (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (e_stage),
        .out   (h_stage)
    );

    jd2d_month u_month (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (h_stage),
        .out   (res)
    );

    assign done          = res.valid;
    assign day_of_month  = res.day_of_month;
    assign month         = res.month;
    assign year          = res.year;
    assign before_christ = res.before_christ;

endmodule
